// ----- rtl/pct_pkg.sv -----
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types, widths and codes of the polygon convexity test core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pct_pkg;

    // Signed Q16.16 vertex coordinates
    localparam int CoordWidth = 32;
    localparam int EdgeWidth  = CoordWidth + 1;
    localparam int ProdWidth  = 2 * EdgeWidth;
    localparam int DiffWidth  = ProdWidth + 1;

    // Triples judged per vertex: the running one and the two wrap-around ones
    localparam int NumTri = 3;
    localparam int TriRun   = 0;
    localparam int TriWrapA = 1;
    localparam int TriWrapB = 2;

    typedef logic signed [CoordWidth-1:0] t_coord;
    typedef logic signed [EdgeWidth-1:0]  t_edge;
    typedef logic signed [ProdWidth-1:0]  t_prod;
    typedef logic signed [DiffWidth-1:0]  t_diff;
    typedef logic [1:0]                   t_count;
    typedef logic [1:0]                   t_verdict;

    localparam t_count SeenNone = 2'd0;
    localparam t_count SeenOne  = 2'd1;
    localparam t_count SeenTwo  = 2'd2;
    localparam t_count SeenFull = 2'd3;

    localparam t_verdict VerdictNotConvex = 2'd0;
    localparam t_verdict VerdictConvex    = 2'd1;
    localparam t_verdict VerdictTooFew    = 2'd2;

    // Edge vectors of one triple (a, b, c): e1 = b - a, e2 = c - b
    typedef struct packed {
        t_edge e1x;
        t_edge e1y;
        t_edge e2x;
        t_edge e2y;
    } t_tri;

    typedef struct packed {
        logic [NumTri-1:0] tri_ok;
        logic              last;
        logic              too_few;
    } t_ctl;

    typedef struct packed {
        logic pos;
        logic neg;
    } t_sign;

    function automatic t_edge edge_of(t_coord b_pt, t_coord a_pt);
        return t_edge'(b_pt) - t_edge'(a_pt);
    endfunction

    function automatic t_tri make_tri(t_coord ax, t_coord ay, t_coord bx, t_coord by,
                                      t_coord cx, t_coord cy);
        t_tri t;
        t.e1x = edge_of(bx, ax);
        t.e1y = edge_of(by, ay);
        t.e2x = edge_of(cx, bx);
        t.e2y = edge_of(cy, by);
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pct_front.sv -----
// ----------------------------------------------------------------------------
// pct_front
// Vertex history and edge-vector formation for the three triples of a request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pct_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_move,
    input  wire pct_pkg::t_coord                       i_x,
    input  wire pct_pkg::t_coord                       i_y,
    input  wire logic                                  i_last,
    output pct_pkg::t_tri [pct_pkg::NumTri-1:0]        o_tri,
    output pct_pkg::t_ctl                              o_ctl
);

    pct_pkg::t_coord r_first_x, r_first_y, r_second_x, r_second_y;
    pct_pkg::t_coord r_prior_x, r_prior_y, r_older_x, r_older_y;
    pct_pkg::t_count r_count;
    pct_pkg::t_count n_count;
    logic            have_two;

    assign have_two = (r_count == pct_pkg::SeenTwo) || (r_count == pct_pkg::SeenFull);

    assign o_tri[pct_pkg::TriRun]   = pct_pkg::make_tri(r_older_x, r_older_y,
                                                        r_prior_x, r_prior_y, i_x, i_y);
    assign o_tri[pct_pkg::TriWrapA] = pct_pkg::make_tri(r_prior_x, r_prior_y, i_x, i_y,
                                                        r_first_x, r_first_y);
    assign o_tri[pct_pkg::TriWrapB] = pct_pkg::make_tri(i_x, i_y, r_first_x, r_first_y,
                                                        r_second_x, r_second_y);

    always_comb begin
        o_ctl                          = '0;
        o_ctl.tri_ok[pct_pkg::TriRun]   = have_two;
        o_ctl.tri_ok[pct_pkg::TriWrapA] = have_two && i_last;
        o_ctl.tri_ok[pct_pkg::TriWrapB] = have_two && i_last;
        o_ctl.last                     = i_last;
        o_ctl.too_few                  = i_last && !have_two;
    end

    always_comb begin
        if (r_count == pct_pkg::SeenFull) begin
            n_count = pct_pkg::SeenFull;
        end else begin
            n_count = r_count + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= pct_pkg::SeenNone;
        end else if (i_move) begin
            // last vertex closes the polygon: start over
            r_count <= i_last ? pct_pkg::SeenNone : n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move) begin
            if (r_count == pct_pkg::SeenNone) begin
                r_first_x <= i_x;
                r_first_y <= i_y;
            end
            if (r_count == pct_pkg::SeenOne) begin
                r_second_x <= i_x;
                r_second_y <= i_y;
            end
            r_older_x <= r_prior_x;
            r_older_y <= r_prior_y;
            r_prior_x <= i_x;
            r_prior_y <= i_y;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pct_cross.sv -----
// ----------------------------------------------------------------------------
// pct_cross
// Cross product of one triple: registered partial products, then sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pct_cross (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire pct_pkg::t_tri i_tri,
    output pct_pkg::t_sign     o_sign
);

    pct_pkg::t_prod r_p, r_q;
    pct_pkg::t_diff diff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= pct_pkg::t_prod'(i_tri.e1x) * pct_pkg::t_prod'(i_tri.e2y);
            r_q <= pct_pkg::t_prod'(i_tri.e1y) * pct_pkg::t_prod'(i_tri.e2x);
        end
    end

    // exact difference, one extra bit so the sign is true
    assign diff       = pct_pkg::t_diff'(r_p) - pct_pkg::t_diff'(r_q);
    assign o_sign.neg = diff[pct_pkg::DiffWidth-1];
    assign o_sign.pos = !diff[pct_pkg::DiffWidth-1] && (diff != '0);

endmodule

`default_nettype wire

// ----- rtl/pct_verdict.sv -----
// ----------------------------------------------------------------------------
// pct_verdict
// Sign accumulation per polygon and final verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pct_verdict (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_move,
    input  wire pct_pkg::t_ctl                     i_ctl,
    input  wire pct_pkg::t_sign [pct_pkg::NumTri-1:0] i_sign,
    output pct_pkg::t_verdict                      o_verdict
);

    logic                      r_saw_pos, r_saw_neg;
    logic                      any_pos, any_neg;
    logic                      all_pos, all_neg;
    logic [pct_pkg::NumTri-1:0] pos_vec, neg_vec;

    always_comb begin
        for (int k = 0; k < pct_pkg::NumTri; k++) begin
            pos_vec[k] = i_sign[k].pos && i_ctl.tri_ok[k];
            neg_vec[k] = i_sign[k].neg && i_ctl.tri_ok[k];
        end
    end

    assign any_pos = |pos_vec;
    assign any_neg = |neg_vec;
    assign all_pos = r_saw_pos || any_pos;
    assign all_neg = r_saw_neg || any_neg;

    always_comb begin
        priority if (i_ctl.too_few) begin
            o_verdict = pct_pkg::VerdictTooFew;
        end else if (all_pos && all_neg) begin
            o_verdict = pct_pkg::VerdictNotConvex;
        end else begin
            o_verdict = pct_pkg::VerdictConvex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saw_pos <= 1'b0;
            r_saw_neg <= 1'b0;
        end else if (i_move) begin
            // drop the flags once the polygon has its verdict
            r_saw_pos <= all_pos && !i_ctl.last;
            r_saw_neg <= all_neg && !i_ctl.last;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/polygon_convexity_test_core.sv -----
// ----------------------------------------------------------------------------
// polygon_convexity_test_core
// Streaming convexity test of polygons by cross-product sign.
// ----------------------------------------------------------------------------
// The verdict shows on o_valid once the last vertex has passed the output register.
// Throughput: one vertex per cycle when not stalled; a four-stage pipeline (input
// register, edge register, product register, output register) with bubble collapsing.
// Reset: synchronous, active low; clears all valid bits, the vertex count and the
// sign flags. Coordinate and product registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module polygon_convexity_test_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire pct_pkg::t_coord   i_vertex_x,
    input  wire pct_pkg::t_coord   i_vertex_y,
    input  wire logic              i_is_last,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output pct_pkg::t_verdict      o_verdict
);

    // stage 1: input register
    logic            r_s1_valid, r_s1_last;
    pct_pkg::t_coord r_s1_x, r_s1_y;
    // stage 2: edge vectors
    logic                                 r_s2_valid;
    pct_pkg::t_tri [pct_pkg::NumTri-1:0]  r_s2_tri;
    pct_pkg::t_ctl                        r_s2_ctl;
    // stage 3: products (inside the cross units)
    logic                                 r_s3_valid;
    pct_pkg::t_ctl                        r_s3_ctl;
    // output register
    logic                                 r_out_valid;
    pct_pkg::t_verdict                    r_out_verdict;

    pct_pkg::t_tri [pct_pkg::NumTri-1:0]  front_tri;
    pct_pkg::t_ctl                        front_ctl;
    pct_pkg::t_sign [pct_pkg::NumTri-1:0] tri_sign;
    pct_pkg::t_verdict                    verdict;

    logic out_rdy, s3_move, s3_free, s2_move, s2_free, s1_move, s1_free, accept;

    assign out_rdy = !r_out_valid || !i_stall;
    // only a last vertex needs the output register
    assign s3_move = r_s3_valid && (!r_s3_ctl.last || out_rdy);
    assign s3_free = !r_s3_valid || s3_move;
    assign s2_move = r_s2_valid && s3_free;
    assign s2_free = !r_s2_valid || s2_move;
    assign s1_move = r_s1_valid && s2_free;
    assign s1_free = !r_s1_valid || s1_move;
    assign accept  = i_valid && s1_free;

    assign o_stall   = !s1_free;
    assign o_valid   = r_out_valid;
    assign o_verdict = r_out_verdict;

    pct_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_move  (s1_move),
        .i_x     (r_s1_x),
        .i_y     (r_s1_y),
        .i_last  (r_s1_last),
        .o_tri   (front_tri),
        .o_ctl   (front_ctl)
    );

    for (genvar k = 0; k < pct_pkg::NumTri; k++) begin : g_cross
        pct_cross u_cross (
            .i_clk  (i_clk),
            .i_en   (s2_move),
            .i_tri  (r_s2_tri[k]),
            .o_sign (tri_sign[k])
        );
    end

    pct_verdict u_verdict (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_move    (s3_move),
        .i_ctl     (r_s3_ctl),
        .i_sign    (tri_sign),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_free) begin
                r_s3_valid <= r_s2_valid;
            end
            if (out_rdy) begin
                r_out_valid <= s3_move && r_s3_ctl.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x    <= i_vertex_x;
            r_s1_y    <= i_vertex_y;
            r_s1_last <= i_is_last;
        end
        if (s1_move) begin
            r_s2_tri <= front_tri;
            r_s2_ctl <= front_ctl;
        end
        if (s2_move) begin
            r_s3_ctl <= r_s2_ctl;
        end
        if (out_rdy && s3_move && r_s3_ctl.last) begin
            r_out_verdict <= verdict;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pct_checker.sv -----
// ----------------------------------------------------------------------------
// pct_checker
// Port-level checks of the polygon convexity test core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pct_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire pct_pkg::t_verdict o_verdict
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_verdict))
        else $error("stalled verdict changed");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_verdict == pct_pkg::VerdictNotConvex) ||
                    (o_verdict == pct_pkg::VerdictConvex) ||
                    (o_verdict == pct_pkg::VerdictTooFew))
        else $error("verdict code out of range");

    // the block only pushes back when its own result is held up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("request stalled without a blocked result");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result right after reset");

endmodule

bind polygon_convexity_test_core pct_checker u_pct_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_verdict (o_verdict)
);

`default_nettype wire
